// ===== rtl/apsp_pkg.sv =====
package apsp_pkg;

  // Default sizes handed to the top level.
  localparam int MaxVerticesDef = 16;
  localparam int WeightBitsDef  = 16;
  localparam int DistBitsDef    = 32;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [4:0] VertexCountReset = 5'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_RIK,
    ST_GIK,
    ST_ROW,
    ST_DONE,
    ST_QCHK,
    ST_WALK,
    ST_WCHK,
    ST_EMRD,
    ST_EMWR,
    ST_FLAG
  } state_e;

  // One result item.
  typedef struct packed {
    logic [3:0]  vertex;
    logic [31:0] cost;
    logic        no_path;
    logic        bad_query;
    logic        done_res;
    logic        last;
  } res_t;

endpackage

// ===== rtl/apsp_outbuf.sv =====
module apsp_outbuf
  import apsp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  res_t push_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic full_q, full_d;
  res_t data_q;

  // A new item may enter in the same cycle that the held one leaves.
  assign push_ready_o = !full_q || out_ready_i;

  always_comb begin
    full_d = full_q;
    if (push_valid_i && push_ready_o) begin
      full_d = 1'b1;
    end else if (out_ready_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i && push_ready_o) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = full_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/all_pairs_shortest_path.sv =====
// A load or an ignored operation leaves the block idle and ready for the next item. A compute
// makes one distance update per cycle along each row of the n active vertices. A query walks
// the predecessor table, then sends the path one result at a time; output stalls hold it.
// Only one item is worked at a time; a result waits in an output register.
// Reset clears the sequencer and sets vertex_count to 16 and leaves the memories as they are.
module all_pairs_shortest_path
  import apsp_pkg::*;
#(
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int WEIGHT_BITS  = WeightBitsDef,
  parameter int DIST_BITS    = DistBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel: vertex_count.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // from_vertex[3:0], to_vertex[7:4], weight[23:8]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // vertex[3:0], cost[35:4], zero fill[39:36]
  output logic [2:0]  m_axis_tuser,   // no_path[0], bad_query[1], done_res[2]
  output logic        m_axis_tlast
);

  localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;
  // Distance word: infinity flag, distance, predecessor valid, predecessor.
  localparam int DWW   = DIST_BITS + VW + 2;
  localparam int XW    = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
  localparam int IW    = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;
  localparam int SW    = DIST_BITS + 1;

  localparam logic signed [XW-1:0] DmaxX = XW'(signed'({1'b0, {(DIST_BITS-1){1'b1}}}));
  localparam logic signed [XW-1:0] DminX = XW'(signed'({1'b1, {(DIST_BITS-1){1'b0}}}));
  localparam logic signed [SW-1:0] DmaxS = SW'(signed'({1'b0, {(DIST_BITS-1){1'b1}}}));
  localparam logic signed [SW-1:0] DminS = SW'(signed'({1'b1, {(DIST_BITS-1){1'b0}}}));

  // Input fields.
  logic [1:0]  in_op;
  logic [3:0]  in_from, in_to;
  logic [15:0] in_weight;
  logic        in_acc;

  assign in_op     = s_axis_tuser;
  assign in_from   = s_axis_tdata[3:0];
  assign in_to     = s_axis_tdata[7:4];
  assign in_weight = s_axis_tdata[23:8];

  // Configuration register; writes are taken at any time.
  logic [4:0]    cfg_q;
  logic [NW-1:0] n_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= VertexCountReset;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Zero acts as one vertex, anything above the array size as the array size.
  always_comb begin
    if (cfg_q == 5'd0) begin
      n_eff = NW'(1);
    end else if (int'(cfg_q) > MAX_VERTICES) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(cfg_q);
    end
  end

  // Sequencer state and counters.
  state_e        state_q, state_d;
  logic [NW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, cnt_q, cnt_d;
  logic          pv_q, pv_d;
  logic [VW-1:0] jp_q, jp_d, src_q, src_d, dst_q, dst_d, cur_q, cur_d;
  logic [VW-1:0] ipred_q, ipred_d;
  logic [AW-1:0] aw_q, aw_d;
  logic          diag_q, diag_d, bad_q, bad_d, ikinf_q, ikinf_d;
  logic [DIST_BITS-1:0] dik_q, dik_d;
  logic [31:0]   cost_q, cost_d;

  // Memory ports.
  logic                   edge_we, edge_re;
  logic [AW-1:0]          edge_waddr, edge_raddr;
  logic [WEIGHT_BITS-1:0] edge_wdata, edge_rdata_q;
  logic                   dist_we, dist_rea, dist_reb;
  logic [AW-1:0]          dist_waddr, dist_raddra, dist_raddrb;
  logic [DWW-1:0]         dist_wdata, rda_q, rdb_q;
  logic                   stk_we, stk_re;
  logic [VW-1:0]          stk_waddr, stk_raddr, stk_wdata, stk_rdata_q;

  logic [WEIGHT_BITS-1:0] edge_mem [DEPTH];
  logic [DWW-1:0]         dist_mem [DEPTH];
  logic [VW-1:0]          stk_mem  [MAX_VERTICES];

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    if (edge_re) begin
      edge_rdata_q <= edge_mem[edge_raddr];
    end
  end

  // Reads and the write never meet on the same entry: a row update never touches row k
  // or column k, port A reads row k, and port B reads the column after the one written.
  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    if (dist_rea) begin
      rda_q <= dist_mem[dist_raddra];
    end
    if (dist_reb) begin
      rdb_q <= dist_mem[dist_raddrb];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

  // Fields of the two distance read words: port A holds (i,k), (k,j), the
  // query entry or a walk entry (src,cur), port B holds (i,j).
  logic                 a_inf, a_pv, b_inf;
  logic [DIST_BITS-1:0] a_dist, b_dist;
  logic [VW-1:0]        a_pred;

  assign a_inf  = rda_q[DWW-1];
  assign a_dist = rda_q[DWW-2 -: DIST_BITS];
  assign a_pv   = rda_q[VW];
  assign a_pred = rda_q[VW-1:0];
  assign b_inf  = rdb_q[DWW-1];
  assign b_dist = rdb_q[DWW-2 -: DIST_BITS];

  // Stored weight, saturated to the distance range for the initial table.
  logic signed [IW-1:0]          w_ext;
  logic signed [XW-1:0]          e_ext;
  logic        [DIST_BITS-1:0]   e_clamp;

  assign w_ext = IW'(signed'(in_weight));
  assign e_ext = XW'(signed'(edge_rdata_q));

  always_comb begin
    if (e_ext > DmaxX) begin
      e_clamp = DmaxX[DIST_BITS-1:0];
    end else if (e_ext < DminX) begin
      e_clamp = DminX[DIST_BITS-1:0];
    end else begin
      e_clamp = e_ext[DIST_BITS-1:0];
    end
  end

  // Relaxation through k: saturating sum and compare against (i,j).
  logic signed [SW-1:0]        sum_w;
  logic        [DIST_BITS-1:0] sum_c;
  logic                        relax;

  assign sum_w = SW'(signed'(dik_q)) + SW'(signed'(a_dist));

  always_comb begin
    if (sum_w > DmaxS) begin
      sum_c = DmaxS[DIST_BITS-1:0];
    end else if (sum_w < DminS) begin
      sum_c = DminS[DIST_BITS-1:0];
    end else begin
      sum_c = sum_w[DIST_BITS-1:0];
    end
  end

  assign relax = (k_q != i_q) && (k_q[VW-1:0] != jp_q) && !ikinf_q && !a_inf &&
                 (b_inf || (signed'(sum_c) < signed'(b_dist)));

  // Output register.
  logic ob_valid, ob_ready, m_valid;
  res_t ob_data, m_data;

  apsp_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (ob_valid),
    .push_ready_o (ob_ready),
    .push_data_i  (ob_data),
    .out_valid_o  (m_valid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_data)
  );

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {4'd0, m_data.cost, m_data.vertex};
  assign m_axis_tuser  = {m_data.done_res, m_data.bad_query, m_data.no_path};
  assign m_axis_tlast  = m_data.last;

  // Items are taken only between operations.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  logic q_bad;
  assign q_bad = (int'(in_from) >= int'(n_eff)) || (int'(in_to) >= int'(n_eff));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_COMPUTE) begin
            state_d = ST_INIT;
          end else if (in_op == OP_QUERY) begin
            state_d = q_bad ? ST_FLAG : ST_QCHK;
          end
        end
      end
      ST_INIT: begin
        if (i_q == n_eff) begin
          state_d = ST_RIK;
        end
      end
      ST_RIK: begin
        if (i_q == n_eff) begin
          if (NW'(k_q + 1'b1) == n_eff) begin
            state_d = ST_DONE;
          end
        end else if (i_q != k_q) begin
          state_d = ST_GIK;
        end
      end
      ST_GIK: state_d = ST_ROW;
      ST_ROW: begin
        if (j_q == n_eff) begin
          state_d = ST_RIK;
        end
      end
      ST_DONE: begin
        if (ob_ready) begin
          state_d = ST_IDLE;
        end
      end
      ST_QCHK: begin
        state_d = (a_inf && (src_q != dst_q)) ? ST_FLAG : ST_WALK;
      end
      ST_WALK: begin
        if (cur_q == src_q) begin
          state_d = ST_EMRD;
        end else if (cnt_q >= n_eff) begin
          state_d = ST_FLAG;
        end else begin
          state_d = ST_WCHK;
        end
      end
      ST_WCHK: state_d = a_pv ? ST_WALK : ST_FLAG;
      ST_EMRD: state_d = ST_EMWR;
      ST_EMWR: begin
        if (ob_ready) begin
          state_d = (cnt_q == '0) ? ST_IDLE : ST_EMRD;
        end
      end
      ST_FLAG: begin
        if (ob_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    i_d = i_q;  j_d = j_q;  k_d = k_q;  cnt_d = cnt_q;  pv_d = pv_q;
    jp_d = jp_q;  src_d = src_q;  dst_d = dst_q;  cur_d = cur_q;
    ipred_d = ipred_q;  aw_d = aw_q;  diag_d = diag_q;  bad_d = bad_q;
    ikinf_d = ikinf_q;  dik_d = dik_q;  cost_d = cost_q;
    edge_we = 1'b0;  edge_re = 1'b0;
    edge_waddr = {VW'(in_from), VW'(in_to)};
    edge_wdata = w_ext[WEIGHT_BITS-1:0];
    edge_raddr = {i_q[VW-1:0], j_q[VW-1:0]};
    dist_we = 1'b0;  dist_rea = 1'b0;  dist_reb = 1'b0;
    dist_waddr = {i_q[VW-1:0], jp_q};
    dist_wdata = {1'b0, sum_c, a_pv, a_pred};
    dist_raddra = {k_q[VW-1:0], j_q[VW-1:0]};
    dist_raddrb = {i_q[VW-1:0], j_q[VW-1:0]};
    stk_we = 1'b0;  stk_re = 1'b0;
    stk_waddr = cnt_q[VW-1:0];
    stk_wdata = a_pred;
    stk_raddr = cnt_q[VW-1:0];
    ob_valid = 1'b0;
    ob_data  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_LOAD) begin
            edge_we = (int'(in_from) < MAX_VERTICES) && (int'(in_to) < MAX_VERTICES);
          end else if (in_op == OP_COMPUTE) begin
            i_d  = '0;
            j_d  = '0;
            pv_d = 1'b0;
          end else if (in_op == OP_QUERY) begin
            bad_d       = q_bad;
            src_d       = VW'(in_from);
            dst_d       = VW'(in_to);
            dist_rea    = !q_bad;
            dist_raddra = {VW'(in_from), VW'(in_to)};
          end
        end
      end
      ST_INIT: begin
        // Write the cell read last cycle, read the next one.
        if (pv_q) begin
          dist_we    = 1'b1;
          dist_waddr = aw_q;
          if (diag_q) begin
            dist_wdata = '0;
          end else if (edge_rdata_q == '0) begin
            dist_wdata = {1'b1, {(DWW-1){1'b0}}};
          end else begin
            dist_wdata = {1'b0, e_clamp, 1'b1, ipred_q};
          end
        end
        if (i_q != n_eff) begin
          edge_re = 1'b1;
          aw_d    = {i_q[VW-1:0], j_q[VW-1:0]};
          diag_d  = (i_q == j_q);
          ipred_d = i_q[VW-1:0];
          pv_d    = 1'b1;
          if (NW'(j_q + 1'b1) == n_eff) begin
            j_d = '0;
            i_d = NW'(i_q + 1'b1);
          end else begin
            j_d = NW'(j_q + 1'b1);
          end
        end else begin
          pv_d = 1'b0;
          i_d  = '0;
          k_d  = '0;
        end
      end
      ST_RIK: begin
        // Row k itself never changes in pass k, so it is skipped.
        if (i_q == n_eff) begin
          i_d = '0;
          k_d = NW'(k_q + 1'b1);
        end else if (i_q == k_q) begin
          i_d = NW'(i_q + 1'b1);
        end else begin
          dist_rea    = 1'b1;
          dist_raddra = {i_q[VW-1:0], k_q[VW-1:0]};
        end
      end
      ST_GIK: begin
        dik_d   = a_dist;
        ikinf_d = a_inf;
        j_d     = '0;
        pv_d    = 1'b0;
      end
      ST_ROW: begin
        // One column a cycle: read (k,j) and (i,j), write back in the following cycle when it relaxes.
        dist_we = pv_q && relax;
        if (j_q != n_eff) begin
          dist_rea = 1'b1;
          dist_reb = 1'b1;
          jp_d     = j_q[VW-1:0];
          pv_d     = 1'b1;
          j_d      = NW'(j_q + 1'b1);
        end else begin
          pv_d = 1'b0;
          i_d  = NW'(i_q + 1'b1);
        end
      end
      ST_DONE: begin
        ob_valid         = 1'b1;
        ob_data.done_res = 1'b1;
        ob_data.last     = 1'b1;
      end
      ST_QCHK: begin
        cost_d    = 32'(signed'(a_dist));
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = dst_q;
        cnt_d     = NW'(1);
        cur_d     = dst_q;
      end
      ST_WALK: begin
        if (cur_q == src_q) begin
          cnt_d = NW'(cnt_q - 1'b1);
        end else if (cnt_q < n_eff) begin
          dist_rea    = 1'b1;
          dist_raddra = {src_q, cur_q};
        end
      end
      ST_WCHK: begin
        if (a_pv) begin
          stk_we = 1'b1;
          cur_d  = a_pred;
          cnt_d  = NW'(cnt_q + 1'b1);
        end
      end
      ST_EMRD: begin
        stk_re = 1'b1;
      end
      ST_EMWR: begin
        // The stack is read from the top, so the source comes out first.
        ob_valid       = 1'b1;
        ob_data.vertex = 4'(stk_rdata_q);
        ob_data.cost   = cost_q;
        ob_data.last   = (cnt_q == '0);
        if (ob_ready && (cnt_q != '0)) begin
          cnt_d = NW'(cnt_q - 1'b1);
        end
      end
      ST_FLAG: begin
        ob_valid          = 1'b1;
        ob_data.bad_query = bad_q;
        ob_data.no_path   = !bad_q;
        ob_data.last      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      bad_q   <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    jp_q    <= jp_d;
    src_q   <= src_d;
    dst_q   <= dst_d;
    cur_q   <= cur_d;
    ipred_q <= ipred_d;
    aw_q    <= aw_d;
    diag_q  <= diag_d;
    ikinf_q <= ikinf_d;
    dik_q   <= dik_d;
    cost_q  <= cost_d;
  end

`ifndef NO_ASSERTIONS
  // The distance table is only written while building or relaxing it.
  a_dist_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_we |-> (state_q == ST_INIT || state_q == ST_ROW))
    else $error("distance table written outside compute");

  // A relaxation never writes row k or column k of its own pass.
  a_row_col_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_we && state_q == ST_ROW) |-> (i_q != k_q && jp_q != k_q[VW-1:0]))
    else $error("relaxation wrote into row or column k");

  // The path walk never holds more vertices than are active.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (cnt_q <= n_eff))
    else $error("path stack overran the vertex count");

  // No result is pushed while input items are being taken.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !ob_valid)
    else $error("result pushed while idle");
`endif

endmodule
